// File: design/pfpcd_pkg.sv
// Shared types, constants and helpers of the parity framed prefix code decoder.
`default_nettype none

package pfpcd_pkg;

   // Field widths
   localparam int CMD_W     = 2;
   localparam int CODE_W    = 16;
   localparam int LEN_W     = 5;
   localparam int SYM_W     = 8;
   localparam int CHAR_W    = 8;
   localparam int CNT_W     = 16;

   // Framing: nine bits per frame, eight of them data
   localparam int FRAME_LEN   = 9;
   localparam int DATA_LEN    = 8;
   localparam int FCNT_W      = 4;
   localparam int STEP_W      = $clog2(DATA_LEN);
   localparam int NIBBLE_W    = 4;
   localparam int LETTER_BASE = 10;

   // Parameter defaults
   localparam int DEF_TRIE_NODES   = 1024;
   localparam int DEF_MAX_CODE_LEN = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_SYMBOLS = 1'b0;
   localparam logic [CNT_W-1:0] MAX_SYMBOLS_RESET = 16'hFFFF;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;

   // ASCII bounds
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_LO = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_HI = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_LO = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_HI = 8'h5A;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_len;
      logic [SYM_W-1:0]  symbol;
      logic [CHAR_W-1:0] hex_char;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] out_symbol;
      logic             table_full;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_WALK   = 2'd2
   } op_kind_type;

   // One unit of back-end work
   typedef struct packed {
      op_kind_type         kind;
      logic [CODE_W-1:0]   code_bits;
      logic [LEN_W-1:0]    code_len;
      logic [SYM_W-1:0]    symbol;
      logic [DATA_LEN-1:0] frame_data;
   } op_type;

   // ASCII hex character to its four-bit value; letters run on from ten
   function automatic logic [NIBBLE_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] v;
      v = '0;
      if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
         v = c - CHAR_DIGIT_LO;
      end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
         v = c - CHAR_LOWER_LO + CHAR_W'(LETTER_BASE);
      end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
         v = c - CHAR_UPPER_LO + CHAR_W'(LETTER_BASE);
      end
      return v[NIBBLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: design/pfpcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfpcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/pfpcd_front.sv
// Front end: accepts words, packs hex bits into parity frames, queues work.
`default_nettype none

module pfpcd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire pfpcd_pkg::req_type req_data,
   output logic                  req_stall,
   input  wire logic             q_full,
   output logic                  q_push,
   output pfpcd_pkg::op_type     q_op
);

   localparam int FL = pfpcd_pkg::FRAME_LEN;
   localparam int FW = pfpcd_pkg::FCNT_W;
   localparam int NW = pfpcd_pkg::NIBBLE_W;

   logic [FL-1:0]    frame_bits_ff, frame_bits_in;
   logic [FW-1:0]    frame_count_ff, frame_count_in;
   logic             accept;
   logic [NW-1:0]    nib;
   logic [FL+NW-1:0] joined;
   logic [FW-1:0]    sum;
   logic [1:0]       rest;
   logic [FL-1:0]    frame;
   logic [NW-1:0]    keep_mask;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify the word and update the frame assembler
   always_comb begin
      nib       = pfpcd_pkg::hex_nibble(req_data.hex_char);
      joined    = {frame_bits_ff, nib};
      sum       = frame_count_ff + FW'(NW);
      // bits of the nibble that spill into the next frame
      rest      = 2'(sum - FW'(FL));
      frame     = FL'(joined >> rest);
      keep_mask = NW'((NW'(1) << rest) - NW'(1));

      frame_bits_in  = frame_bits_ff;
      frame_count_in = frame_count_ff;
      q_push         = 1'b0;
      q_op.kind       = pfpcd_pkg::OP_CLEAR;
      q_op.code_bits  = req_data.code_bits;
      q_op.code_len   = req_data.code_len;
      q_op.symbol     = req_data.symbol;
      q_op.frame_data = frame[FL-1:1];

      if (accept) begin
         unique case (req_data.cmd)
            pfpcd_pkg::CMD_CLEAR: begin
               frame_bits_in  = '0;
               frame_count_in = '0;
               q_push         = 1'b1;
               q_op.kind      = pfpcd_pkg::OP_CLEAR;
            end
            pfpcd_pkg::CMD_INSERT: begin
               q_push    = 1'b1;
               q_op.kind = pfpcd_pkg::OP_INSERT;
            end
            pfpcd_pkg::CMD_DATA: begin
               if (sum >= FW'(FL)) begin
                  frame_count_in = FW'(rest);
                  frame_bits_in  = FL'(nib & keep_mask);
                  // odd parity passes the frame on
                  q_push         = ^frame;
                  q_op.kind      = pfpcd_pkg::OP_WALK;
               end else begin
                  frame_bits_in  = joined[FL-1:0];
                  frame_count_in = sum;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff  <= '0;
         frame_count_ff <= '0;
      end else begin
         frame_bits_ff  <= frame_bits_in;
         frame_count_ff <= frame_count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/pfpcd_queue.sv
// Short FIFO of work between the front and back ends.
`default_nettype none

module pfpcd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pfpcd_pkg::op_type push_op,
   output logic                  full,
   output logic                  valid,
   output pfpcd_pkg::op_type     head,
   input  wire logic             pop
);

   localparam int DEPTH = pfpcd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfpcd_pkg::op_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign valid = count_ff != '0;
   assign head  = entries_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/pfpcd_back.sv
// Back end: trie inserts, frame walks and the result register.
`default_nettype none

module pfpcd_back #(
   parameter int TRIE_NODES   = pfpcd_pkg::DEF_TRIE_NODES,
   parameter int MAX_CODE_LEN = pfpcd_pkg::DEF_MAX_CODE_LEN
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire pfpcd_pkg::op_type             q_op,
   output logic                               q_pop,
   input  wire logic [pfpcd_pkg::CNT_W-1:0]   max_symbols,
   output logic                               rsp_valid,
   output pfpcd_pkg::rsp_type                 rsp_data,
   input  wire logic                          rsp_stall
);

   localparam int NODE_W = $clog2(TRIE_NODES);
   localparam int SLOT_W = NODE_W + 1;
   localparam int SLOTS  = 2 * TRIE_NODES;
   localparam int USED_W = $clog2(TRIE_NODES + 1);
   localparam int SYM_W  = pfpcd_pkg::SYM_W;
   localparam int CODE_W = pfpcd_pkg::CODE_W;
   localparam int LEN_W  = pfpcd_pkg::LEN_W;
   localparam int CNT_W  = pfpcd_pkg::CNT_W;
   localparam int DL     = pfpcd_pkg::DATA_LEN;
   localparam int STEP_W = pfpcd_pkg::STEP_W;

   // A slot holds the child pointer and that child's symbol
   typedef struct packed {
      logic [SYM_W-1:0]  sym;
      logic [NODE_W-1:0] child;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_INS_RD   = 10'b0000000010,
      S_INS_CHK  = 10'b0000000100,
      S_INS_NEW0 = 10'b0000001000,
      S_INS_NEW1 = 10'b0000010000,
      S_INS_LINK = 10'b0000100000,
      S_INS_MARK = 10'b0001000000,
      S_INS_ERR  = 10'b0010000000,
      S_WALK     = 10'b0100000000,
      S_WDONE    = 10'b1000000000
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [USED_W-1:0]   nodes_used_ff, nodes_used_in;
   entry_type           root_ff [2];
   entry_type           root_in [2];
   logic [NODE_W-1:0]   walk_ff, walk_in;
   logic [CNT_W-1:0]    emitted_ff, emitted_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                root_sel_ff, root_sel_in;
   logic [DL-1:0]       bits_ff, bits_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]    pend_sym_ff, pend_sym_in;
   logic                out_valid_ff, out_valid_in;
   pfpcd_pkg::rsp_type  out_data_ff, out_data_in;

   logic                ram_we;
   logic [SLOT_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [SLOT_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;

   entry_type           rd_entry;
   entry_type           new_entry;
   logic                hit;
   logic                emit;
   logic                blocked;
   logic [NODE_W-1:0]   nx_walk;
   logic [NODE_W-1:0]   new_node;
   logic                trie_full;
   logic                last_bit;
   logic                ins_last;
   logic                len_ok;
   logic                can_push;
   logic                push_valid;
   pfpcd_pkg::rsp_type  push_data;

   // Child table with symbols folded in; the two root slots live in flops
   pfpcd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_trie_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign can_push  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      nodes_used_in = nodes_used_ff;
      root_in       = root_ff;
      walk_in       = walk_ff;
      emitted_in    = emitted_ff;
      node_in       = node_ff;
      code_in       = code_ff;
      left_in       = left_ff;
      sym_in        = sym_ff;
      slot_in       = slot_ff;
      root_sel_in   = root_sel_ff;
      bits_in       = bits_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;

      ram_we     = 1'b0;
      ram_waddr  = slot_ff;
      ram_wdata  = '0;
      ram_raddr  = slot_ff;
      q_pop      = 1'b0;
      push_valid = 1'b0;
      push_data  = '0;

      rd_entry  = root_sel_ff ? root_ff[slot_ff[0]] : entry_type'(ram_rdata);
      hit       = (rd_entry.child != '0) && (rd_entry.sym != '0);
      emit      = hit && (emitted_ff < max_symbols);
      nx_walk   = hit ? '0 : rd_entry.child;
      blocked   = emit && pend_valid_ff && !can_push;
      new_node  = NODE_W'(nodes_used_ff);
      new_entry = '{sym: '0, child: new_node};
      trie_full = nodes_used_ff >= USED_W'(TRIE_NODES);
      last_bit  = step_ff == STEP_W'(DL - 1);
      ins_last  = left_ff == LEN_W'(1);
      len_ok    = (q_op.code_len != '0) && (int'(q_op.code_len) <= MAX_CODE_LEN)
                  && (q_op.code_len <= LEN_W'(CODE_W));

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_op.kind)
                  pfpcd_pkg::OP_CLEAR: begin
                     nodes_used_in = USED_W'(1);
                     root_in[0]    = '0;
                     root_in[1]    = '0;
                     walk_in       = '0;
                     emitted_in    = '0;
                  end
                  pfpcd_pkg::OP_INSERT: begin
                     if (len_ok) begin
                        // left-align the code so the next bit is always the MSB
                        code_in  = q_op.code_bits << (LEN_W'(CODE_W) - q_op.code_len);
                        left_in  = q_op.code_len;
                        node_in  = '0;
                        sym_in   = q_op.symbol;
                        state_in = S_INS_RD;
                     end
                  end
                  pfpcd_pkg::OP_WALK: begin
                     slot_in     = {walk_ff, q_op.frame_data[DL-1]};
                     root_sel_in = walk_ff == '0;
                     ram_raddr   = slot_in;
                     bits_in     = q_op.frame_data;
                     step_in     = '0;
                     state_in    = S_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            slot_in     = {node_ff, code_ff[CODE_W-1]};
            root_sel_in = node_ff == '0;
            ram_raddr   = slot_in;
            state_in    = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (rd_entry.child != '0) begin
               node_in  = rd_entry.child;
               code_in  = code_ff << 1;
               left_in  = left_ff - LEN_W'(1);
               state_in = ins_last ? S_INS_MARK : S_INS_RD;
            end else if (trie_full) begin
               state_in = S_INS_ERR;
            end else begin
               state_in = S_INS_NEW0;
            end
         end
         S_INS_NEW0: begin
            ram_we    = 1'b1;
            ram_waddr = {new_node, 1'b0};
            state_in  = S_INS_NEW1;
         end
         S_INS_NEW1: begin
            ram_we    = 1'b1;
            ram_waddr = {new_node, 1'b1};
            state_in  = S_INS_LINK;
         end
         S_INS_LINK: begin
            if (root_sel_ff) begin
               root_in[slot_ff[0]] = new_entry;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = new_entry;
            end
            nodes_used_in = nodes_used_ff + USED_W'(1);
            node_in       = new_node;
            code_in       = code_ff << 1;
            left_in       = left_ff - LEN_W'(1);
            state_in      = ins_last ? S_INS_MARK : S_INS_RD;
         end
         S_INS_MARK: begin
            // slot_ff still points at the slot that links to the final node of the path
            if (root_sel_ff) begin
               root_in[slot_ff[0]] = '{sym: sym_ff, child: node_ff};
            end else begin
               ram_we    = 1'b1;
               ram_wdata = {sym_ff, node_ff};
            end
            state_in = S_IDLE;
         end
         S_INS_ERR: begin
            if (can_push) begin
               push_valid           = 1'b1;
               push_data.out_symbol = '0;
               push_data.table_full = 1'b1;
               push_data.last       = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_WALK: begin
            // one trie read per bit; a stall re-reads the same slot
            if (!blocked) begin
               walk_in = nx_walk;
               if (emit) begin
                  emitted_in = emitted_ff + CNT_W'(1);
                  if (pend_valid_ff) begin
                     push_valid           = 1'b1;
                     push_data.out_symbol = pend_sym_ff;
                  end
                  pend_sym_in   = rd_entry.sym;
                  pend_valid_in = 1'b1;
               end
               if (last_bit) begin
                  state_in = pend_valid_in ? S_WDONE : S_IDLE;
               end else begin
                  slot_in     = {nx_walk, bits_ff[DL-2]};
                  root_sel_in = nx_walk == '0;
                  ram_raddr   = slot_in;
                  bits_in     = bits_ff << 1;
                  step_in     = step_ff + STEP_W'(1);
               end
            end
         end
         S_WDONE: begin
            if (can_push) begin
               push_valid           = 1'b1;
               push_data.out_symbol = pend_sym_ff;
               push_data.last       = 1'b1;
               pend_valid_in        = 1'b0;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      out_valid_in = push_valid || (out_valid_ff && rsp_stall);
      out_data_in  = push_valid ? push_data : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nodes_used_ff <= USED_W'(1);
         root_ff[0]    <= '0;
         root_ff[1]    <= '0;
         walk_ff       <= '0;
         emitted_ff    <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         root_ff       <= root_in;
         walk_ff       <= walk_in;
         emitted_ff    <= emitted_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      code_ff     <= code_in;
      left_ff     <= left_in;
      sym_ff      <= sym_in;
      slot_ff     <= slot_in;
      root_sel_ff <= root_sel_in;
      bits_ff     <= bits_in;
      pend_sym_ff <= pend_sym_in;
      out_data_ff <= out_data_in;
   end

   // Checks
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> can_push)
      else $error("result pushed into a full, stalled output register");

   a_nodes_range: assert property (@(posedge clock) disable iff (reset)
      (nodes_used_ff != '0) && (nodes_used_ff <= USED_W'(TRIE_NODES)))
      else $error("node count out of range");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_WALK || state_ff == S_WDONE))
      else $error("held symbol outside of a frame walk");

   a_ram_not_root: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr[SLOT_W-1:1] != '0))
      else $error("RAM write to a root slot");

   a_link_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_LINK) |=> (nodes_used_ff == $past(nodes_used_ff) + USED_W'(1)))
      else $error("node link did not allocate a node");

endmodule

`default_nettype wire

// File: design/parity_framed_prefix_code_decoder.sv
// Top level of the parity framed prefix code decoder.
//
// Words arrive on the req_ channel (valid/stall): clear, insert code, or one
// hex character. Results leave on the rsp_ channel, one per decoded symbol
// or full-trie report, with last marking the final one caused by an input
// word. The csr_ port holds max_symbols at address 0 (reset 65535).
// The front end takes a word per cycle while its two-entry work queue has
// room; data words that do not finish a nine-bit frame, or finish one with
// even parity, leave no work. The back end pops each queued item in its
// idle state; a clear or an ignored insert ends there. A frame that passes
// then walks the trie, one trie RAM read per data bit, and a last step
// hands on a symbol still held at the end. An insert reads and checks each
// node on its path; a new node also has its two slots cleared and is linked
// in, and a last step attaches the symbol or reports a full trie. Results
// appear in the cycle after the back end makes them.
// Reset empties the trie to its root, clears frame and walk state and sets
// max_symbols; trie RAM contents are only read after they are written.
// A stalled receiver holds the output register; the back end pauses while
// it has a result it cannot push, and the queue keeps taking words until full.
`default_nettype none

module parity_framed_prefix_code_decoder #(
   parameter int TRIE_NODES   = pfpcd_pkg::DEF_TRIE_NODES,
   parameter int MAX_CODE_LEN = pfpcd_pkg::DEF_MAX_CODE_LEN
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire pfpcd_pkg::req_type                 req_data,
   output logic                                    req_stall,
   output logic                                    rsp_valid,
   output pfpcd_pkg::rsp_type                      rsp_data,
   input  wire logic                               rsp_stall,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [pfpcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pfpcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [pfpcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                    csr_pready
);

   localparam int CNT_W = pfpcd_pkg::CNT_W;
   localparam int AW    = pfpcd_pkg::CSR_ADDR_W;
   localparam int DW    = pfpcd_pkg::CSR_DATA_W;

   logic [CNT_W-1:0]  max_symbols_ff, max_symbols_in;
   logic              csr_write;
   logic              q_push;
   pfpcd_pkg::op_type q_push_op;
   logic              q_full;
   logic              q_valid;
   pfpcd_pkg::op_type q_head;
   logic              q_pop;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_symbols_in = max_symbols_ff;
      if (csr_write && csr_paddr[AW-1] == pfpcd_pkg::REG_MAX_SYMBOLS) begin
         max_symbols_in = csr_pwdata[CNT_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[AW-1] == pfpcd_pkg::REG_MAX_SYMBOLS) begin
         csr_prdata = DW'(max_symbols_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_symbols_ff <= pfpcd_pkg::MAX_SYMBOLS_RESET;
      end else begin
         max_symbols_ff <= max_symbols_in;
      end
   end

   pfpcd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .req_stall(req_stall),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_op     (q_push_op)
   );

   pfpcd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .push_op(q_push_op),
      .full   (q_full),
      .valid  (q_valid),
      .head   (q_head),
      .pop    (q_pop)
   );

   pfpcd_back #(
      .TRIE_NODES  (TRIE_NODES),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_op       (q_head),
      .q_pop      (q_pop),
      .max_symbols(max_symbols_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

`default_nettype wire

// File: bench/parity_framed_prefix_code_decoder_tb.sv
// Self-checking bench for the parity framed prefix code decoder: trie mirror, stimulus, checks.
module parity_framed_prefix_code_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRIE_NODES    = pfpcd_pkg::DEF_TRIE_NODES;
   localparam int MAX_LEN       = pfpcd_pkg::DEF_MAX_CODE_LEN;
   localparam int AW            = pfpcd_pkg::CSR_ADDR_W;
   localparam int DW            = pfpcd_pkg::CSR_DATA_W;
   localparam logic [pfpcd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [AW-1:0] MAX_SYMBOLS_ADDR = AW'(4 * pfpcd_pkg::REG_MAX_SYMBOLS);
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 5000;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   pfpcd_pkg::req_type    req_data = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   pfpcd_pkg::rsp_type    rsp_data;
   logic                  rsp_stall = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [AW-1:0]         csr_paddr = '0;
   logic [DW-1:0]         csr_pwdata = '0;
   logic [DW-1:0]         csr_prdata;
   logic                  csr_pready;

   // words waiting to be sent, decoder results still due
   pfpcd_pkg::req_type pending_words[$];
   pfpcd_pkg::rsp_type due_results[$];
   bit                 stream_bits[$];

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          pressure_on = 0;
   int          hold_count = 0;
   int          quiet_cycles = 0;
   int          mismatches = 0;

   // mirror of the decoder state
   logic [9:0]  mirror_child[0:2*TRIE_NODES-1];
   logic [7:0]  mirror_symbol[0:TRIE_NODES-1];
   int unsigned nodes_used;
   logic [8:0]  frame_bits;
   int unsigned frame_count;
   int unsigned walk_node;
   int unsigned emitted;
   logic [15:0] symbol_cap;

   parity_framed_prefix_code_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // empty trie, frame and walk state
   function automatic void clear_mirror();
      mirror_child[0] = '0;
      mirror_child[1] = '0;
      mirror_symbol[0] = '0;
      nodes_used = 1;
      frame_bits = '0;
      frame_count = 0;
      walk_node = 0;
      emitted = 0;
   endfunction

   function automatic void reset_mirror();
      foreach (mirror_child[i]) mirror_child[i] = '0;
      foreach (mirror_symbol[i]) mirror_symbol[i] = '0;
      clear_mirror();
      symbol_cap = pfpcd_pkg::MAX_SYMBOLS_RESET;
   endfunction

   // work out the results of one accepted word and queue them
   function automatic void decode_word(input pfpcd_pkg::req_type w);
      pfpcd_pkg::rsp_type made[$];
      pfpcd_pkg::rsp_type r;
      int unsigned node, slot, fresh, i, k, nx;
      logic [7:0]  c;
      logic [7:0]  v;
      logic [3:0]  nib;
      logic [8:0]  frame;
      bit          full;
      case (w.cmd)
         pfpcd_pkg::CMD_CLEAR: begin
            clear_mirror();
         end
         pfpcd_pkg::CMD_INSERT: begin
            if (w.code_len >= 1 && w.code_len <= MAX_LEN) begin
               node = 0;
               full = 0;
               for (i = 0; i < w.code_len && !full; i++) begin
                  slot = 2 * node + ((w.code_bits >> (w.code_len - 1 - i)) & 1);
                  if (mirror_child[slot] == 0) begin
                     if (nodes_used >= TRIE_NODES) begin
                        full = 1;
                     end else begin
                        fresh = nodes_used;
                        mirror_child[2*fresh] = '0;
                        mirror_child[2*fresh+1] = '0;
                        mirror_symbol[fresh] = '0;
                        mirror_child[slot] = fresh[9:0];
                        nodes_used = fresh + 1;
                     end
                  end
                  if (!full) node = mirror_child[slot];
               end
               if (full) begin
                  r.out_symbol = '0;
                  r.table_full = 1'b1;
                  r.last = 1'b0;
                  made.push_back(r);
               end else begin
                  mirror_symbol[node] = w.symbol;
               end
            end
         end
         pfpcd_pkg::CMD_DATA: begin
            // character to nibble: digits, then letters counting on from ten
            c = w.hex_char;
            v = '0;
            if (c >= pfpcd_pkg::CHAR_DIGIT_LO && c <= pfpcd_pkg::CHAR_DIGIT_HI) begin
               v = c - pfpcd_pkg::CHAR_DIGIT_LO;
            end else if (c >= pfpcd_pkg::CHAR_LOWER_LO && c <= pfpcd_pkg::CHAR_LOWER_HI) begin
               v = c - pfpcd_pkg::CHAR_LOWER_LO + 8'd10;
            end else if (c >= pfpcd_pkg::CHAR_UPPER_LO && c <= pfpcd_pkg::CHAR_UPPER_HI) begin
               v = c - pfpcd_pkg::CHAR_UPPER_LO + 8'd10;
            end
            nib = v[3:0];
            for (i = 0; i < 4; i++) begin
               frame_bits = {frame_bits[7:0], nib[3-i]};
               frame_count++;
               if (frame_count >= pfpcd_pkg::FRAME_LEN) begin
                  frame = frame_bits;
                  frame_count = 0;
                  frame_bits = '0;
                  // odd parity frames walk the trie, others are dropped
                  if (^frame) begin
                     for (k = 0; k < pfpcd_pkg::DATA_LEN; k++) begin
                        nx = mirror_child[2 * walk_node + frame[8-k]];
                        walk_node = nx;
                        if (nx != 0 && mirror_symbol[nx] != 0) begin
                           if (emitted < symbol_cap && made.size() < 8) begin
                              r.out_symbol = mirror_symbol[nx];
                              r.table_full = 1'b0;
                              r.last = 1'b0;
                              made.push_back(r);
                              emitted++;
                           end
                           walk_node = 0;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (made.size() != 0) made[made.size()-1].last = 1'b1;
      foreach (made[j]) due_results.push_back(made[j]);
   endfunction

   // stimulus builders
   function automatic void put_word(input logic [pfpcd_pkg::CMD_W-1:0] cmd,
                                    input logic [15:0] bits,
                                    input logic [4:0] len, input logic [7:0] sym,
                                    input logic [7:0] ch);
      pfpcd_pkg::req_type w;
      w.cmd = cmd;
      w.code_bits = bits;
      w.code_len = len;
      w.symbol = sym;
      w.hex_char = ch;
      pending_words.push_back(w);
   endfunction

   function automatic void put_clear();
      put_word(pfpcd_pkg::CMD_CLEAR, 16'($urandom), 5'($urandom), 8'($urandom),
               8'($urandom));
      stream_bits.delete();
   endfunction

   function automatic void put_insert(input logic [15:0] bits, input logic [4:0] len,
                                      input logic [7:0] sym);
      put_word(pfpcd_pkg::CMD_INSERT, bits, len, sym, 8'($urandom));
   endfunction

   // short codes mostly, symbol zero now and then to drop a mark
   function automatic void put_random_code();
      logic [4:0] len;
      logic [7:0] sym;
      len = ($urandom_range(7) == 0) ? 5'($urandom_range(6, 16)) : 5'($urandom_range(1, 4));
      sym = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      put_insert(16'($urandom), len, sym);
   endfunction

   // one of the spellings that map to this nibble
   function automatic logic [7:0] char_for(input logic [3:0] nib);
      logic [7:0] base;
      int         pick;
      pick = $urandom_range(3);
      base = $urandom_range(1) ? pfpcd_pkg::CHAR_LOWER_LO : pfpcd_pkg::CHAR_UPPER_LO;
      if (pick == 0 && nib <= 9) return base + 8'(nib) + 8'd6;
      if (pick == 1 && nib <= 3) return base + 8'(nib) + 8'd22;
      if (pick == 2 && nib == 0) return 8'h7E;
      if (nib <= 9) return pfpcd_pkg::CHAR_DIGIT_LO + 8'(nib);
      return base + 8'(nib) - 8'd10;
   endfunction

   // frames with odd parity, one in ten broken, cut into hex characters
   function automatic void put_frames(input int count);
      logic [7:0] data;
      logic       par;
      logic [3:0] nib;
      int         k;
      repeat (count) begin
         data = 8'($urandom);
         par = ~^data;
         if ($urandom_range(9) == 0) par = ~par;
         for (k = 7; k >= 0; k--) stream_bits.push_back(data[k]);
         stream_bits.push_back(par);
         while (stream_bits.size() >= 4) begin
            nib = {stream_bits[0], stream_bits[1], stream_bits[2], stream_bits[3]};
            repeat (4) void'(stream_bits.pop_front());
            put_word(pfpcd_pkg::CMD_DATA, 16'($urandom), 5'($urandom), 8'($urandom),
                     char_for(nib));
         end
      end
   endfunction

   // ignored words: unused command or an insert of bad length
   function automatic void put_noise();
      if ($urandom_range(1))
         put_word(CMD_UNUSED, 16'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
      else
         put_insert(16'($urandom), $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31)),
                    8'($urandom));
   endfunction

   // a message: optional raw characters and clear, a code set, then framed data with noise and extra codes mixed in
   function automatic void put_message(input bit clear_first, input int codes, input int frames);
      if (clear_first) begin
         repeat ($urandom_range(2))
            put_word(pfpcd_pkg::CMD_DATA, 16'($urandom), 5'($urandom), 8'($urandom),
                     8'($urandom));
         put_clear();
      end
      repeat (codes) put_random_code();
      repeat (frames) begin
         put_frames(1);
         if ($urandom_range(7) == 0) put_noise();
         if ($urandom_range(11) == 0) put_random_code();
      end
   endfunction

   // wait until everything sent has been answered, then let the back end finish
   task automatic settle();
      while (pending_words.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write max_symbols, then read it back
   task automatic csr_write_max(input logic [15:0] cap);
      logic [DW-1:0] rd;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_SYMBOLS_ADDR;
      csr_pwdata  <= DW'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      symbol_cap = cap;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[15:0] !== cap) begin
         $display("%0t: max_symbols read back, expected %04h actual %04h", $time, cap, rd[15:0]);
         mismatches++;
      end
   endtask

   task automatic start_phase(input idle_mode_type mode, input logic [15:0] cap);
      settle();
      send_idle_pct = (mode == IDLE_SEND) ? 76 : (mode == IDLE_BOTH) ? 10 : 0;
      stall_pct     = (mode == IDLE_STALL) ? 76 : (mode == IDLE_BOTH) ? 10 : 0;
      csr_write_max(cap);
   endtask

   // word driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // expected results follow each accepted word
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) decode_word(req_data);
   end

   // receiver stall, with one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (pressure_on && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      pfpcd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual symbol %02h full %0b last %0b",
                     $time, rsp_data.out_symbol, rsp_data.table_full, rsp_data.last);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data.out_symbol !== want.out_symbol || rsp_data.table_full !== want.table_full
                || rsp_data.last !== want.last) begin
               $write("%0t: expected symbol %02h full %0b last %0b", $time, want.out_symbol,
                      want.table_full, want.last);
               $display(", actual symbol %02h full %0b last %0b", rsp_data.out_symbol,
                        rsp_data.table_full, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset_mirror();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: code set with a prefix symbol and extreme fields
      put_word(pfpcd_pkg::CMD_CLEAR, 16'hFFFF, 5'd31, 8'hFF, 8'hFF);
      put_insert(16'h0000, 5'd1, 8'hFF);
      put_insert(16'h0002, 5'd2, 8'h01);
      put_insert(16'h0006, 5'd3, 8'h80);
      put_insert(16'h000E, 5'd4, 8'h55);
      put_insert(16'hE000, 5'd16, 8'h7E);
      put_insert(16'h0000, 5'd16, 8'h01);
      put_insert(16'hFFFF, 5'd16, 8'hAA);
      // bad lengths and the unused command change nothing
      put_insert(16'hFFFF, 5'd0, 8'h33);
      put_insert(16'hFFFF, 5'd17, 8'h33);
      put_insert(16'hFFFF, 5'd31, 8'h33);
      put_word(CMD_UNUSED, 16'hFFFF, 5'd1, 8'h11, 8'h30);
      // first frame passes parity and decodes several symbols
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "0");
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "9");
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "a");
      // symbol zero drops the mark, so the walk runs past that node
      put_insert(16'h0002, 5'd2, 8'h00);
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "z");
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "A");
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "Z");
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, 8'h40);
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, 8'hFF);
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "7");
      put_word(pfpcd_pkg::CMD_DATA, 16'h0, 5'd0, 8'h0, "f");

      // random messages under several limits and idle patterns
      start_phase(IDLE_NONE, 16'hFFFF);
      put_message(1, 5, 8);
      start_phase(IDLE_SEND, 16'd20);
      put_message(0, 3, 8);
      start_phase(IDLE_STALL, 16'd0);
      put_message(1, 5, 6);
      start_phase(IDLE_BOTH, 16'd1);
      put_message(0, 4, 6);
      start_phase(IDLE_NONE, 16'd3);
      put_message(1, 5, 8);

      // long receiver hold-off while words keep coming
      start_phase(IDLE_STALL, 16'($urandom_range(4, 60)));
      pressure_on = 1;
      put_message(1, 6, 10);

      // long codes until the trie runs out of nodes
      start_phase(IDLE_BOTH, 16'hFFFF);
      put_clear();
      repeat (120) put_insert(16'($urandom), 5'd16, 8'($urandom_range(1, 255)));
      put_frames(6);

      settle();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
